FILE: hdl/pgtc_pkg.sv
// ----------------------------------------------------------------------------
// pgtc_pkg
// Shared types and constants of the per-group transmit counter table:
// transaction payloads, table entry layout, operation codes and registers.
// ----------------------------------------------------------------------------
package pgtc_pkg;

  localparam int MaxGroupsDef = 1024;

  localparam int GroupW     = 10;
  localparam int PktsAddW   = 16;
  localparam int BytesAddW  = 32;
  localparam int SeqW       = 32;
  localparam int CntW       = 64;
  localparam int NumGroupsW = 11;

  // Wide enough for any group count the MAX_GROUPS range allows
  localparam int GrpCmpW = 17;

  // Configuration port
  localparam int PaddrW = 3;
  localparam int PdataW = 32;
  localparam logic REG_NUM_GROUPS = 1'b0;   // register index, paddr[2]
  localparam logic [NumGroupsW-1:0] NumGroupsRst = 11'd1024;

  // Operation codes
  localparam logic [1:0] OP_READ    = 2'd0;
  localparam logic [1:0] OP_INC_SEQ = 2'd1;
  localparam logic [1:0] OP_ADD_CNT = 2'd2;

  typedef struct packed {
    logic [1:0]           operation;
    logic [GroupW-1:0]    group;
    logic [PktsAddW-1:0]  pkts_add;
    logic [BytesAddW-1:0] bytes_add;
  } in_item_t;

  typedef struct packed {
    logic            in_range;
    logic [SeqW-1:0] seq_value;
    logic [CntW-1:0] pkts_total;
    logic [CntW-1:0] bytes_total;
  } out_item_t;

  typedef struct packed {
    logic [SeqW-1:0] seq;
    logic [CntW-1:0] pkts;
    logic [CntW-1:0] bytes;
  } entry_t;

endpackage

FILE: hdl/per_group_tx_counter_table.sv
// ----------------------------------------------------------------------------
// per_group_tx_counter_table
// Per-group transmit statistics: sequence number, packet and byte counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) carries one transaction
//   naming an operation (read, increment sequence, add counts) and a group.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns exactly one
//   result per input transaction, in order.
//   On the accept edge the memory read is issued; in the execute state,
//   once the result slot is free, the entry is modified, written back and
//   the result register loaded, from which the result is then presented.
//   The next read is only issued once the write-back has landed, so no two
//   accesses to one entry overlap.
//   A new transaction is taken while a finished result still waits.
//   A stalled receiver holds the result register; the block then accepts at
//   most one more transaction and holds it, read but not yet modified, until
//   the result slot frees up.
//   After reset all groups clear in a sweep, during which no input
//   transaction is accepted; register writes still land.
//   num_groups (APB, address 0) limits the groups in use; an index at or
//   above it or MAX_GROUPS returns in_range = 0 and all-zero fields.
// ----------------------------------------------------------------------------
module per_group_tx_counter_table #(
  parameter int MAX_GROUPS = pgtc_pkg::MaxGroupsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // input transactions
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  pgtc_pkg::in_item_t          in_data_i,
  // result transactions
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pgtc_pkg::out_item_t         out_data_o,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pgtc_pkg::PaddrW-1:0] paddr,
  input  logic [pgtc_pkg::PdataW-1:0] pwdata,
  output logic [pgtc_pkg::PdataW-1:0] prdata,
  output logic                        pready
);
  import pgtc_pkg::*;

  localparam int IdxW = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam logic [GrpCmpW-1:0] MaxGroupsL = GrpCmpW'(MAX_GROUPS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;

  // Configuration register
  logic [NumGroupsW-1:0] num_groups_q;
  logic                  cfg_wr;

  // Transaction held across the read cycle
  logic [1:0]           op_q;
  logic [IdxW-1:0]      idx_q;
  logic [PktsAddW-1:0]  pkts_add_q;
  logic [BytesAddW-1:0] bytes_add_q;
  logic                 hit_q;

  // Result register
  logic       out_valid_q, out_valid_d;
  out_item_t  out_q;

  // Datapath
  logic [GrpCmpW-1:0] grp_ext;
  logic [IdxW-1:0]    in_idx;
  logic               in_hit;
  logic               in_fire;
  logic               exec_fire;
  logic               slot_free;
  entry_t             rd_entry;
  entry_t             new_entry;
  logic               wr_en;
  logic               tbl_busy;

  // --------------------------------------------------------------------------
  // APB register access: one register, always ready
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_NUM_GROUPS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_groups_q <= NumGroupsRst;
    end else if (cfg_wr) begin
      num_groups_q <= pwdata[NumGroupsW-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_NUM_GROUPS) begin
      prdata = PdataW'(num_groups_q);
    end
  end

  // --------------------------------------------------------------------------
  // Accept: range check and issue the memory read in the same edge
  // --------------------------------------------------------------------------
  assign grp_ext = GrpCmpW'(in_data_i.group);
  assign in_idx  = grp_ext[IdxW-1:0];
  assign in_hit  = (grp_ext < GrpCmpW'(num_groups_q)) && (grp_ext < MaxGroupsL);

  assign in_ready_o = (state_q == ST_IDLE) && !tbl_busy;
  assign in_fire    = in_valid_i && in_ready_o;

  // The result slot frees when empty or when its result leaves this cycle
  assign slot_free  = !out_valid_q || out_ready_i;
  assign exec_fire  = (state_q == ST_EXEC) && slot_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_fire)   state_d = ST_EXEC;
      ST_EXEC: if (exec_fire) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Hold the transaction while the entry is read
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q        <= in_data_i.operation;
      idx_q       <= in_idx;
      pkts_add_q  <= in_data_i.pkts_add;
      bytes_add_q <= in_data_i.bytes_add;
      hit_q       <= in_hit;
    end
  end

  // --------------------------------------------------------------------------
  // Modify: counters and sequence wrap at their widths
  // --------------------------------------------------------------------------
  always_comb begin
    new_entry = rd_entry;
    wr_en     = 1'b0;
    unique case (op_q)
      OP_INC_SEQ: begin
        new_entry.seq = rd_entry.seq + SeqW'(1);
        wr_en         = exec_fire && hit_q;
      end
      OP_ADD_CNT: begin
        new_entry.pkts  = rd_entry.pkts + CntW'(pkts_add_q);
        new_entry.bytes = rd_entry.bytes + CntW'(bytes_add_q);
        wr_en           = exec_fire && hit_q;
      end
      default: begin
        // read and the unused code leave the entry as it is
        new_entry = rd_entry;
      end
    endcase
  end

  pgtc_table #(
    .DEPTH (MAX_GROUPS),
    .IDX_W (IdxW)
  ) u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_idx_i  (in_idx),
    .rd_data_o (rd_entry),
    .wr_en_i   (wr_en),
    .wr_idx_i  (idx_q),
    .wr_data_i (new_entry),
    .busy_o    (tbl_busy)
  );

  // --------------------------------------------------------------------------
  // Result register: load on execute, drop when taken
  // --------------------------------------------------------------------------
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (exec_fire) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) begin
      if (hit_q) begin
        out_q.in_range    <= 1'b1;
        out_q.seq_value   <= rd_entry.seq;
        out_q.pkts_total  <= new_entry.pkts;
        out_q.bytes_total <= new_entry.bytes;
      end else begin
        out_q <= '0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: hdl/pgtc_table.sv
// ----------------------------------------------------------------------------
// pgtc_table
// Statistics memory, one entry per group, with a registered read
// and a clearing sweep over all entries after reset.
// ----------------------------------------------------------------------------
module pgtc_table #(
  parameter int DEPTH = pgtc_pkg::MaxGroupsDef,
  parameter int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 rd_en_i,
  input  logic [IDX_W-1:0]     rd_idx_i,
  output pgtc_pkg::entry_t     rd_data_o,
  input  logic                 wr_en_i,
  input  logic [IDX_W-1:0]     wr_idx_i,
  input  pgtc_pkg::entry_t     wr_data_i,
  output logic                 busy_o
);
  import pgtc_pkg::*;

  entry_t             mem [DEPTH];
  entry_t             rd_data_q;
  logic               clearing_q, clearing_d;
  logic [IDX_W-1:0]   clr_idx_q, clr_idx_d;

  // Sweep every entry once after reset
  always_comb begin
    clearing_d = clearing_q;
    clr_idx_d  = clr_idx_q;
    if (clearing_q) begin
      clr_idx_d = clr_idx_q + 1'b1;
      if (clr_idx_q == IDX_W'(DEPTH - 1)) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_idx_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_idx_q  <= clr_idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_idx_q] <= '0;
    end else if (wr_en_i) begin
      mem[wr_idx_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_data_q;
  assign busy_o    = clearing_q;

endmodule
